// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high
`define OPDD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define OPDD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/opdd_pkg.sv
package opdd_pkg;

   // Tick counter width and saturation value
   localparam int COUNT_WIDTH = 8;
   localparam int THR_WIDTH   = 8;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam int MV_WIDTH = 13;

   // Voltage thresholds in millivolts
   localparam logic [MV_WIDTH-1:0] MV_EQ_TOL     = 13'd50;
   localparam logic [MV_WIDTH-1:0] MV_NONE_HI    = 13'd3700;
   localparam logic [MV_WIDTH-1:0] MV_NONE_LO    = 13'd2800;
   localparam logic [MV_WIDTH-1:0] MV_MINI_MAX   = 13'd2000;
   localparam logic [MV_WIDTH-1:0] MV_ERR_MAX    = 13'd1600;
   localparam logic [MV_WIDTH-1:0] MV_BAL_HI     = 13'd2600;
   localparam logic [MV_WIDTH-1:0] MV_BAL_LO     = 13'd2400;
   localparam logic [MV_WIDTH-1:0] MV_SHORT_HI   = 13'd850;
   localparam logic [MV_WIDTH-1:0] MV_SHORT_LO   = 13'd650;
   localparam logic [MV_WIDTH-1:0] MV_NEWTACHO   = 13'd450;
   localparam logic [MV_WIDTH-1:0] MV_MINITACHO  = 13'd250;
   localparam logic [MV_WIDTH-1:0] MV_GROUND_MAX = 13'd100;

   // Register indexes on the control port
   typedef enum logic [1:0] {
      CSR_AUTO_ENABLE  = 2'd0,
      CSR_SETTLE_TICKS = 2'd1,
      CSR_ADD_TICKS    = 2'd2,
      CSR_REMOVE_TICKS = 2'd3
   } csr_addr_type;

   typedef enum logic [2:0] {
      PH_INIT        = 3'd0,
      PH_INIT_SETTLE = 3'd1,
      PH_NO_DEV      = 3'd2,
      PH_PIN6_SETTLE = 3'd3,
      PH_CONNECTED   = 3'd4,
      PH_PIN5_SETTLE = 3'd5,
      PH_DEV_CONN    = 3'd6,
      PH_WAIT_DISC   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NONE      = 3'd0,
      KIND_NEWTACHO  = 3'd1,
      KIND_MINITACHO = 3'd2,
      KIND_TACHO     = 3'd3,
      KIND_ERR       = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PIN6_NOP     = 2'd0,
      PIN6_LOW     = 2'd1,
      PIN6_RELEASE = 2'd2
   } pin6_act_type;

   typedef enum logic [1:0] {
      PIN5_NOP  = 2'd0,
      PIN5_HIGH = 2'd1,
      PIN5_LOW  = 2'd2
   } pin5_act_type;

   // Pin flag bits
   localparam int FLAG_LOADED = 0;
   localparam int FLAG_PIN6   = 1;

   typedef struct packed {
      logic                 auto_enable;
      logic [THR_WIDTH-1:0] settle_ticks;
      logic [THR_WIDTH-1:0] add_ticks;
      logic [THR_WIDTH-1:0] remove_ticks;
   } cfg_type;

   typedef struct packed {
      logic                worker_busy;
      logic                motor_registered;
      logic                pin6_high;
      logic [MV_WIDTH-1:0] pin5_mv;
   } tick_type;

   typedef struct packed {
      logic         request_unregister;
      logic         request_register;
      pin5_act_type pin5_action;
      pin6_act_type pin6_action;
      logic         float_port;
      kind_type     motor_kind;
      phase_type    phase;
   } result_type;

   localparam int REQ_WIDTH = 16;
   localparam int RSP_WIDTH = 16;

   // Counter has reached a threshold
   function automatic logic cnt_reached(input logic [COUNT_WIDTH-1:0] cnt,
                                        input logic [THR_WIDTH-1:0] thr);
      return CMP_WIDTH'(cnt) >= CMP_WIDTH'(thr);
   endfunction

   // Pin five is pulled away from the mid rail
   function automatic logic out_of_balance(input logic [MV_WIDTH-1:0] mv);
      return (mv < MV_BAL_LO) || (mv > MV_BAL_HI);
   endfunction

endpackage

// File: hdl/opdd_csr.sv
module opdd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_addr,
   input  logic [opdd_pkg::THR_WIDTH-1:0]     csr_wdata,
   output opdd_pkg::cfg_type                  cfg
);
   import opdd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_AUTO_ENABLE:  cfg_in.auto_enable  = csr_wdata[0];
            CSR_SETTLE_TICKS: cfg_in.settle_ticks = csr_wdata;
            CSR_ADD_TICKS:    cfg_in.add_ticks    = csr_wdata;
            CSR_REMOVE_TICKS: cfg_in.remove_ticks = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_enable  <= 1'b1;
         cfg_ff.settle_ticks <= THR_WIDTH'(2);
         cfg_ff.add_ticks    <= THR_WIDTH'(35);
         cfg_ff.remove_ticks <= THR_WIDTH'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/opdd_fsm.sv
module opdd_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  opdd_pkg::tick_type   tick,
   input  opdd_pkg::cfg_type    cfg,
   output opdd_pkg::result_type result
);
   import opdd_pkg::*;
   `include "assert_macros.svh"

   phase_type               phase_ff, phase_in;
   kind_type                kind_ff, kind_in;
   logic [COUNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [1:0]              flags_ff, flags_in;
   logic [MV_WIDTH-1:0]     float_mv_ff, float_mv_in;
   logic [MV_WIDTH-1:0]     low_mv_ff, low_mv_in;

   // Shared decisions
   logic [COUNT_WIDTH-1:0]  cnt_inc;
   logic [COUNT_WIDTH-1:0]  cnt_nodev;
   logic [COUNT_WIDTH-1:0]  cnt_disc;
   logic [1:0]              new_flags;
   logic                    settle_done;
   logic                    add_done;
   logic                    remove_done;
   logic [MV_WIDTH-1:0]     mv_diff;
   logic                    probe_err;
   logic                    probe_direct;
   kind_type                direct_kind;
   kind_type                pin5_kind;

   logic                    flt;
   pin6_act_type            a6;
   pin5_act_type            a5;
   logic                    rq;
   logic                    urq;

   // Counter, pin flags and voltage classification
   always_comb begin
      cnt_inc = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + COUNT_WIDTH'(1);
      new_flags[FLAG_PIN6]   = tick.pin6_high;
      new_flags[FLAG_LOADED] = out_of_balance(tick.pin5_mv);
      cnt_nodev   = (new_flags != flags_ff) ? '0 : cnt_inc;
      cnt_disc    = out_of_balance(tick.pin5_mv) ? '0 : cnt_inc;
      settle_done = cnt_reached(cnt_inc, cfg.settle_ticks);
      add_done    = (new_flags != 2'b00) && cnt_reached(cnt_nodev, cfg.add_ticks);
      remove_done = cnt_reached(cnt_disc, cfg.remove_ticks) && !tick.worker_busy;

      mv_diff = (float_mv_ff >= low_mv_ff) ? float_mv_ff - low_mv_ff
                                           : low_mv_ff - float_mv_ff;
      probe_err = (mv_diff >= MV_EQ_TOL)
         || (!out_of_balance(float_mv_ff) && flags_ff[FLAG_PIN6])
         || (float_mv_ff < MV_GROUND_MAX)
         || (float_mv_ff >= MV_SHORT_LO && float_mv_ff <= MV_SHORT_HI)
         || (float_mv_ff >= MV_NONE_LO && float_mv_ff <= MV_NONE_HI);
      probe_direct = float_mv_ff < MV_BAL_LO;

      priority if (float_mv_ff > MV_NEWTACHO) begin
         direct_kind = KIND_NEWTACHO;
      end else if (float_mv_ff > MV_MINITACHO) begin
         direct_kind = KIND_MINITACHO;
      end else begin
         direct_kind = KIND_TACHO;
      end

      priority if (tick.pin5_mv < MV_ERR_MAX) begin
         pin5_kind = KIND_ERR;
      end else if (tick.pin5_mv < MV_MINI_MAX) begin
         pin5_kind = KIND_MINITACHO;
      end else begin
         pin5_kind = KIND_TACHO;
      end
   end

   // Next state
   always_comb begin
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      cnt_in      = cnt_ff;
      flags_in    = flags_ff;
      float_mv_in = float_mv_ff;
      low_mv_in   = low_mv_ff;
      if (!cfg.auto_enable) begin
         phase_in = PH_INIT;
      end else begin
         cnt_in = cnt_inc;
         unique case (phase_ff)
            PH_INIT: begin
               if (!tick.motor_registered) begin
                  cnt_in   = '0;
                  kind_in  = KIND_NONE;
                  phase_in = PH_INIT_SETTLE;
               end
            end
            PH_INIT_SETTLE: begin
               if (settle_done) begin
                  cnt_in   = '0;
                  phase_in = PH_NO_DEV;
               end
            end
            PH_NO_DEV: begin
               flags_in = new_flags;
               cnt_in   = cnt_nodev;
               if (add_done) begin
                  float_mv_in = tick.pin5_mv;
                  cnt_in      = '0;
                  phase_in    = PH_PIN6_SETTLE;
               end
            end
            PH_PIN6_SETTLE: begin
               if (settle_done) begin
                  low_mv_in = tick.pin5_mv;
                  cnt_in    = '0;
                  phase_in  = PH_CONNECTED;
               end
            end
            PH_CONNECTED: begin
               priority if (probe_err) begin
                  kind_in  = KIND_ERR;
                  phase_in = PH_WAIT_DISC;
               end else if (probe_direct) begin
                  kind_in  = direct_kind;
                  phase_in = PH_DEV_CONN;
               end else begin
                  cnt_in   = '0;
                  phase_in = PH_PIN5_SETTLE;
               end
            end
            PH_PIN5_SETTLE: begin
               if (settle_done) begin
                  low_mv_in = tick.pin5_mv;
                  cnt_in    = '0;
                  kind_in   = pin5_kind;
                  phase_in  = PH_DEV_CONN;
               end
            end
            PH_DEV_CONN: begin
               cnt_in = '0;
               if (kind_ff != KIND_ERR && !tick.worker_busy) begin
                  phase_in = PH_WAIT_DISC;
               end
            end
            PH_WAIT_DISC: begin
               cnt_in = cnt_disc;
               if (remove_done) begin
                  phase_in = PH_INIT;
               end
            end
         endcase
      end
   end

   // Port commands for this tick
   always_comb begin
      flt = 1'b0;
      a6  = PIN6_NOP;
      a5  = PIN5_NOP;
      rq  = 1'b0;
      urq = 1'b0;
      if (cfg.auto_enable) begin
         unique case (phase_ff)
            PH_INIT:        flt = !tick.motor_registered;
            PH_INIT_SETTLE: ;
            PH_NO_DEV:      if (add_done) a6 = PIN6_LOW;
            PH_PIN6_SETTLE: if (settle_done) a6 = PIN6_RELEASE;
            PH_CONNECTED:   if (!probe_err && !probe_direct) a5 = PIN5_HIGH;
            PH_PIN5_SETTLE: if (settle_done) a5 = PIN5_LOW;
            PH_DEV_CONN:    rq = (kind_ff != KIND_ERR) && !tick.worker_busy;
            PH_WAIT_DISC:   urq = remove_done;
         endcase
      end
   end

   // Commit state once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_INIT;
         kind_ff     <= KIND_NONE;
         cnt_ff      <= '0;
         flags_ff    <= '0;
         float_mv_ff <= '0;
         low_mv_ff   <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         kind_ff     <= kind_in;
         cnt_ff      <= cnt_in;
         flags_ff    <= flags_in;
         float_mv_ff <= float_mv_in;
         low_mv_ff   <= low_mv_in;
      end
   end

   always_comb begin
      result.phase              = phase_in;
      result.motor_kind         = kind_in;
      result.float_port         = flt;
      result.pin6_action        = a6;
      result.pin5_action        = a5;
      result.request_register   = rq;
      result.request_unregister = urq;
   end

   `OPDD_ASSERT(a_reg_leads_to_wait, clock, reset,
      step && rq |=> phase_ff == PH_WAIT_DISC,
      "register request did not move to waiting for disconnect")
   `OPDD_ASSERT(a_err_stays, clock, reset,
      step && cfg.auto_enable && phase_ff == PH_DEV_CONN && kind_ff == KIND_ERR
         |=> phase_ff == PH_DEV_CONN && kind_ff == KIND_ERR,
      "error device left the connected phase")
   `OPDD_ASSERT(a_float_clears_kind, clock, reset,
      step && flt |=> phase_ff == PH_INIT_SETTLE && kind_ff == KIND_NONE && cnt_ff == '0,
      "floating the port did not restart settling")

endmodule

// File: hdl/output_port_device_detector.sv
// Detects what is plugged into a motor output port, one poll tick per word. A tick word is
// taken in every clock cycle unless the input is stalled; it passes the input register, then
// the detection state machine's single pass, then the result register, and back-pressure on
// the result side stalls only once both registers are full. The thresholds on the csr port
// are read as tick counts and must be written while no tick is in flight.
module output_port_device_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pin5_mv[12:0], pin6_high[13], motor_registered[14], worker_busy[15]
   input  logic [opdd_pkg::REQ_WIDTH-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // phase[2:0], motor_kind[5:3], float_port[6], pin6_action[8:7], pin5_action[10:9],
   // request_register[11], request_unregister[12], zero[15:13]
   output logic [opdd_pkg::RSP_WIDTH-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_addr,
   input  logic [opdd_pkg::THR_WIDTH-1:0]      csr_wdata
);
   import opdd_pkg::*;
   `include "assert_macros.svh"

   cfg_type    cfg;
   tick_type   tick_ff;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       accept;

   opdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   opdd_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .tick   (tick_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Move the held tick into the result register when there is room
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         tick_ff <= tick_type'(req_tdata);
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'(out_ff);

   `OPDD_ASSERT(a_stall_means_full, clock, reset,
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready,
      "input stalled while a register was free")

endmodule
